// ===== rtl/wth_pkg.sv =====
// Types and constants shared by the window table hit test block.
// Holds the input and result words, the cell command and chain words, and the opcodes.
// No dependencies.
package wth_pkg;

  localparam int WINDOW_SLOTS_DEF = 16;
  localparam int SLOT_IDX_W       = 8;
  localparam int DEPTH_W          = 32;
  localparam int COORD_W          = 16;
  localparam int SIZE_W           = 16;
  localparam int WIN_W            = 4;
  localparam int OPCODE_W         = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE      = 3'd0,
    OP_DESTROY     = 3'd1,
    OP_MOVE        = 3'd2,
    OP_SET_VISIBLE = 3'd3,
    OP_FOCUS       = 3'd4,
    OP_HIT_TEST    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [WIN_W-1:0]          window_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]         surface_width;
    logic [SIZE_W-1:0]         surface_height;
    logic                      visible_flag;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic [WIN_W-1:0] window_out;
  } out_word_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic                      write_en;
    logic [SLOT_IDX_W-1:0]     index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic                      visible_flag;
    logic [DEPTH_W-1:0]        depth;
  } cell_cmd_t;

  typedef struct packed {
    logic                  token;
    logic                  found;
    logic [DEPTH_W-1:0]    depth;
    logic [SLOT_IDX_W-1:0] index;
  } chain_t;

  typedef struct packed {
    logic used;
    logic visible;
  } cell_stat_t;

endpackage

// ===== rtl/wth_cell.sv =====
// One window slot of the table, a link in the scan chain.
// Applies broadcast edits and handles the scan word as it passes by.
// Depends on wth_pkg.
module wth_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wth_pkg::cell_cmd_t  cmd,
  input  wth_pkg::chain_t     chain_in,
  output wth_pkg::chain_t     chain_out,
  output wth_pkg::cell_stat_t stat
);
  import wth_pkg::*;

  logic                      used_r, used_nxt;
  logic                      vis_r, vis_nxt;
  logic                      foc_r, foc_nxt;
  logic signed [COORD_W-1:0] x_r, x_nxt;
  logic signed [COORD_W-1:0] y_r, y_nxt;
  logic [SIZE_W-1:0]         w_r, w_nxt;
  logic [SIZE_W-1:0]         h_r, h_nxt;
  logic [DEPTH_W-1:0]        depth_r, depth_nxt;
  chain_t                    chain_r, chain_nxt;

  logic              target;
  logic              take;
  logic              hit;
  logic [COORD_W:0]  dx;
  logic [COORD_W:0]  dy;
  logic              in_x;
  logic              in_y;

  assign target = cmd.write_en && (cmd.index == SLOT_IDX_W'(CELL_INDEX));
  assign take   = chain_in.token && (cmd.opcode == OP_CREATE) && !chain_in.found && !used_r;

  assign dx   = {cmd.pos_x[COORD_W-1], cmd.pos_x} - {x_r[COORD_W-1], x_r};
  assign dy   = {cmd.pos_y[COORD_W-1], cmd.pos_y} - {y_r[COORD_W-1], y_r};
  assign in_x = !dx[COORD_W] && (dx[COORD_W-1:0] < w_r);
  assign in_y = !dy[COORD_W] && (dy[COORD_W-1:0] < h_r);
  assign hit  = chain_in.token && (cmd.opcode == OP_HIT_TEST) && used_r && vis_r &&
                in_x && in_y;

  always_comb begin
    chain_nxt = chain_in;
    if (take) begin
      chain_nxt.found = 1'b1;
      chain_nxt.index = SLOT_IDX_W'(CELL_INDEX);
    end else if (hit && (!chain_in.found || depth_r >= chain_in.depth)) begin
      chain_nxt.found = 1'b1;
      chain_nxt.depth = depth_r;
      chain_nxt.index = SLOT_IDX_W'(CELL_INDEX);
    end
  end

  always_comb begin
    used_nxt  = used_r;
    vis_nxt   = vis_r;
    foc_nxt   = foc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    depth_nxt = depth_r;
    if (take) begin
      used_nxt  = 1'b1;
      vis_nxt   = 1'b1;
      foc_nxt   = 1'b0;
      x_nxt     = cmd.pos_x;
      y_nxt     = cmd.pos_y;
      w_nxt     = cmd.width;
      h_nxt     = cmd.height;
      depth_nxt = cmd.depth;
    end else if (cmd.write_en) begin
      case (cmd.opcode)
        OP_DESTROY: begin
          if (target) begin
            used_nxt = 1'b0;
            vis_nxt  = 1'b0;
            foc_nxt  = 1'b0;
          end
        end
        OP_MOVE: begin
          if (target) begin
            x_nxt = cmd.pos_x;
            y_nxt = cmd.pos_y;
          end
        end
        OP_SET_VISIBLE: begin
          if (target) begin
            vis_nxt = cmd.visible_flag;
            if (!cmd.visible_flag) foc_nxt = 1'b0;
          end
        end
        OP_FOCUS: begin
          foc_nxt = 1'b0;
          if (target) begin
            foc_nxt   = 1'b1;
            depth_nxt = cmd.depth;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r        <= 1'b0;
      vis_r         <= 1'b0;
      foc_r         <= 1'b0;
      chain_r.token <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      vis_r   <= vis_nxt;
      foc_r   <= foc_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    depth_r <= depth_nxt;
  end

  assign chain_out    = chain_r;
  assign stat.used    = used_r;
  assign stat.visible = vis_r & foc_r | vis_r;

endmodule

// ===== rtl/window_table_hit_test_top.sv =====
// Top level of the window table hit test block: control sequencer and the row of slot cells.
// Depends on wth_pkg and wth_cell.
//
// A table of WINDOW_SLOTS window slots, one per cell. Create and hit test send a scan word
// down the row of cells, one cell per clock, and load their result once the scan word has
// left the last cell; destroy, move, set visible, focus and unknown opcodes load it without
// a scan. One word is in flight at a time: the input opens again in the cycle after the
// previous result is loaded into the output register, even while that result still waits to
// be taken.
module window_table_hit_test_top #(
  parameter int WINDOW_SLOTS = wth_pkg::WINDOW_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wth_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wth_pkg::out_word_t out_data
);
  import wth_pkg::*;

  localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [SLOT_IDX_W:0] SLOTS_C = (SLOT_IDX_W+1)'(WINDOW_SLOTS);

  ctrl_state_t        state_r, state_nxt;
  in_word_t           cmd_r;
  chain_t             launch_r;
  out_word_t          res_r;
  out_word_t          out_r, out_nxt;
  logic               out_valid_r;
  logic [DEPTH_W-1:0] next_depth_r;

  chain_t     chain_w [WINDOW_SLOTS+1];
  cell_stat_t stat_w  [WINDOW_SLOTS];
  cell_cmd_t  cmd_w;

  logic                  in_accept;
  logic                  out_free;
  logic                  is_scan_op;
  logic [SLOT_IDX_W-1:0] idx_ext;
  logic [IDX_W-1:0]      sel;
  logic                  in_range;
  logic                  base_ok;
  logic                  op_ok;
  logic                  launch;
  logic                  commit;
  logic                  capture;
  logic                  out_load;
  chain_t                last;

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign is_scan_op = (cmd_r.opcode == OP_CREATE) || (cmd_r.opcode == OP_HIT_TEST);
  assign last       = chain_w[WINDOW_SLOTS];

  assign idx_ext  = SLOT_IDX_W'(cmd_r.window_index);
  assign sel      = idx_ext[IDX_W-1:0];
  assign in_range = {1'b0, idx_ext} < SLOTS_C;
  assign base_ok  = in_range && stat_w[sel].used;

  always_comb begin
    case (cmd_r.opcode)
      OP_DESTROY, OP_MOVE, OP_SET_VISIBLE: op_ok = base_ok;
      OP_FOCUS:                            op_ok = base_ok && stat_w[sel].visible;
      default:                             op_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (is_scan_op) state_nxt = ST_SCAN;
        else if (out_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: if (last.token) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    launch   = 1'b0;
    commit   = 1'b0;
    capture  = 1'b0;
    out_load = 1'b0;
    out_nxt  = res_r;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: begin
        if (is_scan_op) begin
          launch = 1'b1;
        end else if (out_free) begin
          commit             = op_ok;
          out_load           = 1'b1;
          out_nxt.status     = !op_ok;
          out_nxt.window_out = '0;
        end
      end
      ST_SCAN: capture = last.token;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    cmd_w.opcode       = cmd_r.opcode;
    cmd_w.write_en     = commit;
    cmd_w.index        = idx_ext;
    cmd_w.pos_x        = cmd_r.pos_x;
    cmd_w.pos_y        = cmd_r.pos_y;
    cmd_w.width        = cmd_r.surface_width;
    cmd_w.height       = cmd_r.surface_height;
    cmd_w.visible_flag = cmd_r.visible_flag;
    cmd_w.depth        = next_depth_r;
  end

  assign chain_w[0] = launch_r;

  for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_cell
    wth_cell #(
      .CELL_INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd_w),
      .chain_in  (chain_w[g]),
      .chain_out (chain_w[g+1]),
      .stat      (stat_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      launch_r     <= '0;
      out_valid_r  <= 1'b0;
      next_depth_r <= '0;
    end else begin
      state_r        <= state_nxt;
      launch_r.token <= launch;
      launch_r.found <= 1'b0;
      launch_r.depth <= '0;
      launch_r.index <= '0;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if ((capture && last.found && (cmd_r.opcode == OP_CREATE)) ||
          (commit && (cmd_r.opcode == OP_FOCUS))) begin
        next_depth_r <= next_depth_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) cmd_r <= in_data;
    if (capture) begin
      res_r.status     <= !last.found;
      res_r.window_out <= last.found ? last.index[WIN_W-1:0] : '0;
    end
    if (out_load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
